@@ src/radix12_signed_add_sub_top_defines.svh @@
// assertion macros used by the top-level rtl
`ifndef RADIX12_SIGNED_ADD_SUB_TOP_DEFINES_SVH
`define RADIX12_SIGNED_ADD_SUB_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rss assertion failed");
`define RSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rss assertion failed");
`else
`define RSS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RSS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/rss_pkg.sv @@
package rss_pkg;

    localparam int DIGITS = 7;
    localparam int RADIX  = 12;
    localparam int MAG_W  = DIGITS * 4;
    localparam int RES_W  = (DIGITS + 1) * 4;

    typedef struct packed {
        logic             a_negative;
        logic [MAG_W-1:0] a_digits;
        logic             b_negative;
        logic [MAG_W-1:0] b_digits;
    } t_in;

    typedef struct packed {
        logic             sum_negative;
        logic [RES_W-1:0] sum_digits;
        logic             diff_negative;
        logic [RES_W-1:0] diff_digits;
        logic             digit_error;
    } t_out;

    // record carried down the digit chain
    typedef struct packed {
        logic [MAG_W-1:0] big;
        logic [MAG_W-1:0] small_mag;
        logic [MAG_W-1:0] sum_acc;
        logic [MAG_W-1:0] diff_acc;
        logic             carry;
        logic             borrow;
        logic             same_sign;
        logic             sum_neg;
        logic             diff_neg;
        logic             err;
    } t_cell;

    function automatic logic bad_digit(input logic [3:0] d);
        return d[3] & d[2];
    endfunction

endpackage

@@ src/rss_cell.sv @@
module rss_cell
    import rss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_cell i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_cell o_data
);

    logic       r_valid;
    t_cell      r_data;
    t_cell      n_data;
    logic [4:0] s_sum;
    logic [4:0] s_q;
    logic [4:0] s_p;
    logic [4:0] s_diff;
    logic       s_carry;
    logic       s_borrow;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // one digit of add and subtract, lowest remaining digit
    always_comb begin
        s_p   = {1'b0, i_data.big[3:0]};
        s_sum = s_p + {1'b0, i_data.small_mag[3:0]} + {4'b0, i_data.carry};
        if (s_sum >= 5'(RADIX)) begin
            s_sum   = s_sum - 5'(RADIX);
            s_carry = 1'b1;
        end else begin
            s_carry = 1'b0;
        end
        s_q = {1'b0, i_data.small_mag[3:0]} + {4'b0, i_data.borrow};
        if (s_p < s_q) begin
            s_diff   = s_p + 5'(RADIX) - s_q;
            s_borrow = 1'b1;
        end else begin
            s_diff   = s_p - s_q;
            s_borrow = 1'b0;
        end
        n_data           = i_data;
        n_data.big       = {4'b0, i_data.big[MAG_W-1:4]};
        n_data.small_mag = {4'b0, i_data.small_mag[MAG_W-1:4]};
        n_data.sum_acc   = {s_sum[3:0], i_data.sum_acc[MAG_W-1:4]};
        n_data.diff_acc  = {s_diff[3:0], i_data.diff_acc[MAG_W-1:4]};
        n_data.carry     = s_carry;
        n_data.borrow    = s_borrow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

@@ src/rss_finish.sv @@
module rss_finish
    import rss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_cell i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_out  o_data
);

    logic             r_valid;
    t_out             r_data;
    t_out             n_data;
    logic [RES_W-1:0] s_total;
    logic [RES_W-1:0] s_delta;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // pick magnitudes by sign, zero is positive; a digit error clears the result
    always_comb begin
        s_total = {3'b0, i_data.carry, i_data.sum_acc};
        s_delta = {4'b0, i_data.diff_acc};
        if (i_data.same_sign) begin
            n_data.sum_digits  = s_total;
            n_data.diff_digits = s_delta;
        end else begin
            n_data.sum_digits  = s_delta;
            n_data.diff_digits = s_total;
        end
        n_data.sum_negative  = i_data.sum_neg && (n_data.sum_digits != '0);
        n_data.diff_negative = i_data.diff_neg && (n_data.diff_digits != '0);
        n_data.digit_error   = i_data.err;
        if (i_data.err) begin
            n_data.sum_digits    = '0;
            n_data.diff_digits   = '0;
            n_data.sum_negative  = 1'b0;
            n_data.diff_negative = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

@@ src/radix12_signed_add_sub_top.sv @@
// channel  | direction | handshake                  | payload
// in       | input     | i_in_valid / o_in_ready    | i_in_data  (t_in)
// out      | output    | o_out_valid / i_out_ready  | o_out_data (t_out)
//
// one transaction per cycle unless the output stalls; seven digit cells plus
// the output register; each cell handles one digit and passes carry and borrow on
// every stage holds its own valid, so bubbles close up while the output stalls
// synchronous active-low reset clears the valid bits only
`include "radix12_signed_add_sub_top_defines.svh"

module radix12_signed_add_sub_top
    import rss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_cell       s_prep;
    logic        s_err;
    logic        s_b_bigger;
    t_cell       s_chain_data  [DIGITS+1];
    logic        s_chain_valid [DIGITS+1];
    logic        s_chain_ready [DIGITS+1];

    // digit check, magnitude compare and swap, result signs
    always_comb begin
        s_err = 1'b0;
        for (int k = 0; k < DIGITS; k++) begin
            s_err = s_err | bad_digit(i_in_data.a_digits[4*k +: 4])
                          | bad_digit(i_in_data.b_digits[4*k +: 4]);
        end
        s_b_bigger         = i_in_data.b_digits > i_in_data.a_digits;
        s_prep.big         = s_b_bigger ? i_in_data.b_digits : i_in_data.a_digits;
        s_prep.small_mag   = s_b_bigger ? i_in_data.a_digits : i_in_data.b_digits;
        s_prep.sum_acc     = '0;
        s_prep.diff_acc    = '0;
        s_prep.carry       = 1'b0;
        s_prep.borrow      = 1'b0;
        s_prep.same_sign   = i_in_data.a_negative == i_in_data.b_negative;
        if (s_prep.same_sign) begin
            s_prep.sum_neg  = i_in_data.a_negative;
            s_prep.diff_neg = i_in_data.a_negative ^ s_b_bigger;
        end else begin
            s_prep.sum_neg  = i_in_data.a_negative ^ s_b_bigger;
            s_prep.diff_neg = i_in_data.a_negative;
        end
        s_prep.err = s_err;
    end

    assign s_chain_data[0]  = s_prep;
    assign s_chain_valid[0] = i_in_valid;
    assign o_in_ready       = s_chain_ready[0];

    for (genvar g = 0; g < DIGITS; g++) begin : g_cell
        rss_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_chain_valid[g]),
            .o_ready (s_chain_ready[g]),
            .i_data  (s_chain_data[g]),
            .o_valid (s_chain_valid[g+1]),
            .i_ready (s_chain_ready[g+1]),
            .o_data  (s_chain_data[g+1])
        );
    end

    rss_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_chain_valid[DIGITS]),
        .o_ready (s_chain_ready[DIGITS]),
        .i_data  (s_chain_data[DIGITS]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    `RSS_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_out_valid && o_out_data.digit_error,
        o_out_data.sum_digits == '0 && o_out_data.diff_digits == '0
        && !o_out_data.sum_negative && !o_out_data.diff_negative)
    `RSS_ASSERT_IMP(a_sum_zero_pos, i_clk, i_rst_n, o_out_valid && o_out_data.sum_digits == '0,
        !o_out_data.sum_negative)
    `RSS_ASSERT_IMP(a_diff_zero_pos, i_clk, i_rst_n, o_out_valid && o_out_data.diff_digits == '0,
        !o_out_data.diff_negative)
    `RSS_ASSERT_IMP(a_top_digit, i_clk, i_rst_n, o_out_valid,
        o_out_data.sum_digits[RES_W-1:RES_W-3] == '0
        && o_out_data.diff_digits[RES_W-1:RES_W-3] == '0)
    `RSS_ASSERT_IMP(a_in_ready, i_clk, i_rst_n, !o_out_valid, o_in_ready)

endmodule
